[hdl/hamming_sphere_enumerator_macros.svh]
// Assertion macros shared by the Hamming sphere enumerator RTL.
`ifndef HAMMING_SPHERE_ENUMERATOR_MACROS_SVH
`define HAMMING_SPHERE_ENUMERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/hse_pkg.sv]
// Package with the shared constants and types of the Hamming sphere enumerator.
`timescale 1ns / 1ps
package hse_pkg;

	localparam int DEF_MAX_BITS   = 64;
	localparam int DEF_MAX_RADIUS = 8;

	localparam int DATA_W = 64;    // width of origin and neighbour fields
	localparam int LEN_W  = 7;     // vector_length register width
	localparam int RAD_W  = 4;     // radius register width
	localparam int CFG_W  = 7;     // configuration data width (widest register)
	localparam int IDX_W  = 2;     // configuration index width
	localparam int CMP_W  = 8;     // width used for position and length compares

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_NEXT  = 1'b1;

	localparam logic [IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_RADIUS        = 2'd1;

	// Control handed from the sequencer to every flip cell.
	typedef struct packed {
		logic             init;    // load positions 0..r-1
		logic             step;    // move to the lexicographic successor
		logic [LEN_W-1:0] len;     // effective vector length n
		logic [RAD_W-1:0] radius;  // radius r
	} hse_ctrl_t;

endpackage

[hdl/hamming_sphere_enumerator.sv]
// Top level of the Hamming sphere enumerator: stream ports, sequencer and the flip cell chain.
`timescale 1ns / 1ps
// Usage
// The block walks through every vector at Hamming distance r from a stored origin.
// Input beats arrive on s_tvalid/s_tready; s_tuser carries the action (start or next)
// and s_tdata the origin, which is read only on start. Every input beat produces exactly
// one output beat on m_tvalid/m_tready with the neighbour, a status flag and a flag that
// tells whether another next request would still produce a neighbour.
// The user must write vector_length (n) and radius (r) via cfg_we, cfg_index and cfg_data
// only while the block is idle (not enforced); a write rearms enumeration, keeps the origin.
// Steps: the accepting edge already moves the flip positions through the cell chain and
// puts the sequencer into its evaluation state; that state evaluates the same chain on the
// new positions for the more_left flag, decodes the flip mask and loads the output
// register once it is free. The block does not take a new input beat while it evaluates
// the last one.
// The output register lets the block accept the next input beat while a result still
// waits; if the receiver stalls longer, that item waits in its evaluation state with
// s_tready low until the output register is free.
// Reset clears the origin and the positions, sets n to 64 and r to 1, and arms the
// enumeration so that the first next request yields positions 0..r-1.
module hamming_sphere_enumerator #(
	parameter int MAX_BITS   = hse_pkg::DEF_MAX_BITS,
	parameter int MAX_RADIUS = hse_pkg::DEF_MAX_RADIUS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [hse_pkg::DATA_W-1:0]  s_tdata,   // [63:0] origin
	input  logic [0:0]                  s_tuser,   // [0] action
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [71:0]                 m_tdata,   // [63:0] neighbour, [64] more_left, rest zero
	output logic [0:0]                  m_tuser,   // [0] status
	// configuration writes
	input  logic                        cfg_we,
	input  logic [hse_pkg::IDX_W-1:0]   cfg_index,
	input  logic [hse_pkg::CFG_W-1:0]   cfg_data
);
	import hse_pkg::*;

`include "hamming_sphere_enumerator_macros.svh"

	localparam int PW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EVAL = 2'b10
	} state_t;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_ADVANCE,
		KIND_EXHAUSTED
	} kind_t;

	state_t              state_q;
	kind_t               kind_q;
	logic [LEN_W-1:0]    vlen_q;
	logic [RAD_W-1:0]    radius_q;
	logic [MAX_BITS-1:0] origin_q;
	logic                first_q;

	logic [DATA_W-1:0]   out_data_q;
	logic                out_status_q;
	logic                out_more_q;
	logic                out_valid_q;

	logic [LEN_W-1:0]    n_eff;
	logic                empty;
	logic                more_now;
	logic                accept;
	logic                is_next;
	logic                load_out;
	hse_ctrl_t           ctrl;

	// Chain links: bump and pos travel down from cell i+1 to cell i,
	// follow, val and mask travel up from cell i-1 to cell i.
	logic                bump_link   [MAX_RADIUS+1];
	logic [PW-1:0]       pos_link    [MAX_RADIUS+1];
	logic                follow_link [MAX_RADIUS+1];
	logic [PW-1:0]       val_link    [MAX_RADIUS+1];
	logic [MAX_BITS-1:0] mask_link   [MAX_RADIUS+1];

	// A length above the configured maximum acts as the maximum.
	assign n_eff = (CMP_W'(vlen_q) > CMP_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : vlen_q;

	assign empty = (radius_q == '0) || (n_eff == '0) ||
	               (CMP_W'(radius_q) > CMP_W'(n_eff)) ||
	               (CMP_W'(radius_q) > CMP_W'(MAX_RADIUS));

	// Another neighbour exists when the sphere is not empty and either the walk has
	// not begun or some active cell can still move up.
	assign more_now = !empty && (first_q || bump_link[0]);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_next  = (s_tuser[0] == ACT_NEXT);

	assign ctrl.init   = accept && is_next && more_now && first_q;
	assign ctrl.step   = accept && is_next && more_now && !first_q;
	assign ctrl.len    = n_eff;
	assign ctrl.radius = radius_q;

	assign bump_link[MAX_RADIUS] = 1'b0;
	assign pos_link[MAX_RADIUS]  = '0;
	assign follow_link[0]        = 1'b0;
	assign val_link[0]           = '0;
	assign mask_link[0]          = '0;

	for (genvar gi = 0; gi < MAX_RADIUS; gi++) begin : g_cell
		hse_flip_cell #(
			.MAX_BITS (MAX_BITS),
			.IDX      (gi)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.upper_bump   (bump_link[gi+1]),
			.upper_pos    (pos_link[gi+1]),
			.lower_follow (follow_link[gi]),
			.lower_val    (val_link[gi]),
			.lower_mask   (mask_link[gi]),
			.bump_out     (bump_link[gi]),
			.pos_out      (pos_link[gi]),
			.follow_out   (follow_link[gi+1]),
			.val_out      (val_link[gi+1]),
			.mask_out     (mask_link[gi+1])
		);
	end

	// Sequencer, configuration registers and the stored origin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= KIND_START;
			vlen_q   <= LEN_W'(64);
			radius_q <= RAD_W'(1);
			origin_q <= '0;
			first_q  <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VECTOR_LENGTH: begin
						vlen_q  <= cfg_data[LEN_W-1:0];
						first_q <= 1'b1;
					end
					REG_RADIUS: begin
						radius_q <= cfg_data[RAD_W-1:0];
						first_q  <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
						if (!is_next) begin
							origin_q <= s_tdata[MAX_BITS-1:0];
							first_q  <= 1'b1;
							kind_q   <= KIND_START;
						end else if (!more_now) begin
							kind_q <= KIND_EXHAUSTED;
						end else begin
							first_q <= 1'b0;
							kind_q  <= KIND_ADVANCE;
						end
					end
				end
				ST_EVAL: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: the result is formed from the updated positions.
	assign load_out = (state_q == ST_EVAL) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (kind_q == KIND_ADVANCE) begin
				out_data_q <= DATA_W'(origin_q ^ mask_link[MAX_RADIUS]);
			end else begin
				out_data_q <= DATA_W'(origin_q);
			end
			out_status_q <= (kind_q == KIND_EXHAUSTED);
			out_more_q   <= (kind_q != KIND_EXHAUSTED) && more_now;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_more_q, out_data_q};
	assign m_tuser  = out_status_q;

	// An accepted beat always moves the sequencer to its evaluation cycle.
	`HSE_ASSERT_NEXT(a_accept_to_eval, clk, arst_n, accept, state_q == ST_EVAL,
		"accepted beat did not enter evaluation")
	// An exhausted result never claims that more neighbours remain.
	`HSE_ASSERT_NOW(a_exhausted_no_more, clk, arst_n, m_tvalid && m_tuser[0], !m_tdata[64],
		"exhausted result reports more neighbours")
	// A start beat rearms the walk.
	`HSE_ASSERT_NEXT(a_start_rearms, clk, arst_n, accept && !is_next, first_q,
		"start beat did not rearm the enumeration")

endmodule

[hdl/hse_flip_cell.sv]
// One flip cell: holds one sorted flip position and takes part in the successor chain.
`timescale 1ns / 1ps
module hse_flip_cell #(
	parameter int MAX_BITS = hse_pkg::DEF_MAX_BITS,
	parameter int IDX      = 0,
	localparam int PW      = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hse_pkg::hse_ctrl_t  ctrl,
	input  logic                upper_bump,
	input  logic [PW-1:0]       upper_pos,
	input  logic                lower_follow,
	input  logic [PW-1:0]       lower_val,
	input  logic [MAX_BITS-1:0] lower_mask,
	output logic                bump_out,
	output logic [PW-1:0]       pos_out,
	output logic                follow_out,
	output logic [PW-1:0]       val_out,
	output logic [MAX_BITS-1:0] mask_out
);
	import hse_pkg::*;

	logic [PW-1:0]    pos_q;
	logic [CMP_W-1:0] inc_c;
	logic [CMP_W-1:0] r_c;
	logic             active;
	logic             is_top;
	logic             bump_own;
	logic             pivot;
	logic [PW-1:0]    val_next;

	assign r_c    = CMP_W'(ctrl.radius);
	assign active = CMP_W'(IDX) < r_c;
	assign is_top = CMP_W'(IDX + 1) == r_c;
	assign inc_c  = CMP_W'(pos_q) + CMP_W'(1);

	// The top active cell may climb up to n-1; the others only into a gap below the next cell.
	assign bump_own = active && (is_top ? (inc_c < CMP_W'(ctrl.len))
	                                    : (inc_c < CMP_W'(upper_pos)));
	assign pivot    = bump_own && !upper_bump;

	always_comb begin
		if (pivot) begin
			val_next = pos_q + PW'(1);
		end else if (active && lower_follow) begin
			val_next = lower_val + PW'(1);
		end else begin
			val_next = pos_q;
		end
	end

	assign bump_out   = upper_bump || bump_own;
	assign pos_out    = pos_q;
	assign follow_out = active && (pivot || lower_follow);
	assign val_out    = val_next;
	assign mask_out   = lower_mask | (active ? (MAX_BITS'(1) << pos_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (ctrl.init) begin
			if (active) begin
				pos_q <= PW'(IDX);
			end
		end else if (ctrl.step) begin
			pos_q <= val_next;
		end
	end

endmodule
